[hw/rtl/q2e_pkg.sv]
// Shared types and constants for the quaternion to Euler angle converter.
// Holds the CORDIC arctangent table and the data carried between pipeline cells.
// No dependencies.
package q2e_pkg;

    // field widths
    localparam int IN_W    = 16;
    localparam int ROLL_W  = 16;
    localparam int PITCH_W = 15;
    localparam int YAW_W   = 16;

    // datapath widths: Q5.30 terms, CORDIC vectors, Q.30 angle accumulator
    localparam int TERM_W = 35;
    localparam int CW     = 37;
    localparam int ZW     = 35;
    localparam int RAD_W  = 61;
    localparam int ROOT_W = 31;
    localparam int SQRT_STEPS = 31;
    localparam int RES_W  = ZW - 16;

    localparam logic signed [TERM_W-1:0] ONE_Q30 = TERM_W'(64'sd1073741824);
    localparam logic signed [ZW-1:0]     PI_Q30  = ZW'(64'sd3373259426);
    localparam logic signed [RES_W-1:0]  FULL_LIMIT = RES_W'(25736);
    localparam logic signed [RES_W-1:0]  HALF_LIMIT = RES_W'(12868);

    // atan(2^-i) in Q.30, rounded down
    localparam logic [29:0] ATAN_TAB [32] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
        30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
        30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
        30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255,
        30'd127, 30'd63, 30'd31, 30'd15, 30'd7, 30'd3, 30'd1, 30'd0, 30'd0
    };

    // rotation terms carried alongside the root extraction
    typedef struct packed {
        logic signed [TERM_W-1:0] t0;
        logic signed [TERM_W-1:0] t1;
        logic signed [TERM_W-1:0] t2;
        logic signed [TERM_W-1:0] t3;
        logic signed [TERM_W-1:0] t4;
    } terms_t;

    // one step of the integer square root
    typedef struct packed {
        logic [RAD_W-1:0] rem;
        logic [RAD_W-1:0] root;
        terms_t           terms;
    } sqrt_t;

    // one CORDIC lane
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } cordic_t;

endpackage

[hw/rtl/q2e_sqrt_cell.sv]
// One digit step of the pipelined integer square root.
// Carries the rotation terms along unchanged. Depends on q2e_pkg.
module q2e_sqrt_cell #(
    parameter int K = 0
) (
    input  logic           clk,
    input  logic           en,
    input  q2e_pkg::sqrt_t d,
    output q2e_pkg::sqrt_t q
);
    import q2e_pkg::*;

    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 1 - 2 * K);

    logic [RAD_W:0] trial;
    sqrt_t          q_next;
    sqrt_t          q_reg;

    // restoring step: try root + bit against the remainder
    always_comb
    begin
        trial  = {1'b0, d.root} + {1'b0, BIT};
        q_next = d;
        if ({1'b0, d.rem} >= trial)
        begin
            q_next.rem  = d.rem - trial[RAD_W-1:0];
            q_next.root = (d.root >> 1) + BIT;
        end
        else
        begin
            q_next.root = d.root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

[hw/rtl/q2e_cordic_cell.sv]
// One vectoring iteration of the CORDIC arctangent, shift fixed by I.
// Depends on q2e_pkg for the lane type and the arctangent table.
module q2e_cordic_cell #(
    parameter int I = 0
) (
    input  logic             clk,
    input  logic             en,
    input  q2e_pkg::cordic_t d,
    output q2e_pkg::cordic_t q
);
    import q2e_pkg::*;

    localparam logic signed [ZW-1:0] STEP = ZW'(ATAN_TAB[I]);

    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    cordic_t              q_next;
    cordic_t              q_reg;

    // rotate towards the x axis
    always_comb
    begin
        xs     = d.x >>> I;
        ys     = d.y >>> I;
        q_next = d;
        if (!d.y[CW-1])
        begin
            q_next.x = d.x + ys;
            q_next.y = d.y - xs;
            q_next.z = d.z + STEP;
        end
        else
        begin
            q_next.x = d.x - ys;
            q_next.y = d.y + xs;
            q_next.z = d.z - STEP;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

[hw/rtl/quaternion_to_euler.sv]
// Top level: quaternion (Q1.15) to ZYX Euler angles (Q3.13 radians; pitch Q2.13).
// Uses q2e_pkg, q2e_sqrt_cell and q2e_cordic_cell.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-------------------------------------
//   quat     | quat_valid / quat_ready   | quat_w, quat_x, quat_y, quat_z
//   euler    | euler_valid / euler_ready | roll_angle, pitch_angle, yaw_angle
//
// One transfer per cycle in, one per cycle out, while the output is not held.
// Stages: products, terms, square, 31 root cells, quadrant fold, one cell per
// CORDIC iteration, output register.
// The whole row advances together; it stalls only while the output is held.
// Reset clears the valid bits only.
module quaternion_to_euler #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               quat_valid,
    output logic                               quat_ready,
    input  logic signed [q2e_pkg::IN_W-1:0]    quat_w,
    input  logic signed [q2e_pkg::IN_W-1:0]    quat_x,
    input  logic signed [q2e_pkg::IN_W-1:0]    quat_y,
    input  logic signed [q2e_pkg::IN_W-1:0]    quat_z,
    output logic                               euler_valid,
    input  logic                               euler_ready,
    output logic signed [q2e_pkg::ROLL_W-1:0]  roll_angle,
    output logic signed [q2e_pkg::PITCH_W-1:0] pitch_angle,
    output logic signed [q2e_pkg::YAW_W-1:0]   yaw_angle
);
    import q2e_pkg::*;

    localparam int N      = CORDIC_ITERATIONS;
    localparam int STAGES = 36 + N;

    typedef struct packed {
        logic signed [31:0] wy;
        logic signed [31:0] xz;
        logic signed [31:0] yz;
        logic signed [31:0] wx;
        logic signed [31:0] xy;
        logic signed [31:0] wz;
        logic signed [31:0] xx;
        logic signed [31:0] yy;
        logic signed [31:0] zz;
    } prod_t;

    logic                     en;
    logic [STAGES-1:0]        vld_reg;
    prod_t                    prod_reg;
    terms_t                   terms_reg;
    terms_t                   terms_next;
    logic signed [TERM_W-1:0] t2_raw;
    logic [ROOT_W-1:0]        mag;
    logic [2*ROOT_W-1:0]      sq;
    sqrt_t                    sq_reg;
    sqrt_t                    sqrt_pipe [SQRT_STEPS+1];
    cordic_t                  roll_pipe [N+1];
    cordic_t                  pitch_pipe [N+1];
    cordic_t                  yaw_pipe [N+1];
    cordic_t                  roll_reg;
    cordic_t                  pitch_reg;
    cordic_t                  yaw_reg;
    logic signed [ROLL_W-1:0]  roll_out_reg;
    logic signed [PITCH_W-1:0] pitch_out_reg;
    logic signed [YAW_W-1:0]   yaw_out_reg;

    // fold the left half-plane and flag the undefined origin
    function automatic cordic_t cordic_pre(input logic signed [CW-1:0] y,
                                           input logic signed [CW-1:0] x);
        cordic_t c;
        c.zero = (x == '0) && (y == '0);
        c.x    = x;
        c.y    = y;
        c.z    = '0;
        if (x[CW-1])
        begin
            c.z = y[CW-1] ? -PI_Q30 : PI_Q30;
            c.x = -x;
            c.y = -y;
        end
        return c;
    endfunction

    // Q.30 angle to Q3.13, rounded, clamped
    function automatic logic signed [RES_W-1:0] to_q13(input cordic_t c,
                                                       input logic signed [RES_W-1:0] lim);
        logic signed [ZW:0]      s;
        logic signed [RES_W-1:0] r;
        s = {c.z[ZW-1], c.z} + (ZW+1)'(65536);
        r = s[ZW:17];
        if (c.zero)
        begin
            r = '0;
        end
        else if (r > lim)
        begin
            r = lim;
        end
        else if (r < -lim)
        begin
            r = -lim;
        end
        return r;
    endfunction

    // global advance: the row moves unless a finished result is held
    assign en         = !vld_reg[STAGES-1] || euler_ready;
    assign quat_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], quat_valid};
        end
    end

    // pairwise products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg.wy <= 32'(quat_w) * 32'(quat_y);
            prod_reg.xz <= 32'(quat_x) * 32'(quat_z);
            prod_reg.yz <= 32'(quat_y) * 32'(quat_z);
            prod_reg.wx <= 32'(quat_w) * 32'(quat_x);
            prod_reg.xy <= 32'(quat_x) * 32'(quat_y);
            prod_reg.wz <= 32'(quat_w) * 32'(quat_z);
            prod_reg.xx <= 32'(quat_x) * 32'(quat_x);
            prod_reg.yy <= 32'(quat_y) * 32'(quat_y);
            prod_reg.zz <= 32'(quat_z) * 32'(quat_z);
        end
    end

    // rotation terms, pitch term clamped to [-1, 1]
    always_comb
    begin
        terms_next.t0 = ONE_Q30 - ((TERM_W'(prod_reg.yy) + TERM_W'(prod_reg.zz)) <<< 1);
        terms_next.t1 = (TERM_W'(prod_reg.xy) + TERM_W'(prod_reg.wz)) <<< 1;
        t2_raw        = (TERM_W'(prod_reg.wy) - TERM_W'(prod_reg.xz)) <<< 1;
        terms_next.t3 = (TERM_W'(prod_reg.yz) + TERM_W'(prod_reg.wx)) <<< 1;
        terms_next.t4 = ONE_Q30 - ((TERM_W'(prod_reg.xx) + TERM_W'(prod_reg.yy)) <<< 1);
        if (t2_raw > ONE_Q30)
        begin
            terms_next.t2 = ONE_Q30;
        end
        else if (t2_raw < -ONE_Q30)
        begin
            terms_next.t2 = -ONE_Q30;
        end
        else
        begin
            terms_next.t2 = t2_raw;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            terms_reg <= terms_next;
        end
    end

    // radicand 1 - t2^2 in Q.60
    always_comb
    begin
        mag = terms_reg.t2[TERM_W-1] ? ROOT_W'(-terms_reg.t2) : ROOT_W'(terms_reg.t2);
        sq  = mag * mag;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg.rem   <= (RAD_W'(1) << (RAD_W - 1)) - sq[RAD_W-1:0];
            sq_reg.root  <= '0;
            sq_reg.terms <= terms_reg;
        end
    end

    // square root cell row
    assign sqrt_pipe[0] = sq_reg;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        q2e_sqrt_cell #(.K(k)) u_cell (
            .clk (clk),
            .en  (en),
            .d   (sqrt_pipe[k]),
            .q   (sqrt_pipe[k+1])
        );
    end

    // quadrant fold for the three lanes
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_reg  <= cordic_pre(CW'(sqrt_pipe[SQRT_STEPS].terms.t3),
                                    CW'(sqrt_pipe[SQRT_STEPS].terms.t4));
            pitch_reg <= cordic_pre(CW'(sqrt_pipe[SQRT_STEPS].terms.t2),
                                    CW'({1'b0, sqrt_pipe[SQRT_STEPS].root[ROOT_W-1:0]}));
            yaw_reg   <= cordic_pre(CW'(sqrt_pipe[SQRT_STEPS].terms.t1),
                                    CW'(sqrt_pipe[SQRT_STEPS].terms.t0));
        end
    end

    // CORDIC cell rows
    assign roll_pipe[0]  = roll_reg;
    assign pitch_pipe[0] = pitch_reg;
    assign yaw_pipe[0]   = yaw_reg;

    for (genvar i = 0; i < N; i++)
    begin : g_cordic
        q2e_cordic_cell #(.I(i)) u_roll (
            .clk (clk),
            .en  (en),
            .d   (roll_pipe[i]),
            .q   (roll_pipe[i+1])
        );
        q2e_cordic_cell #(.I(i)) u_pitch (
            .clk (clk),
            .en  (en),
            .d   (pitch_pipe[i]),
            .q   (pitch_pipe[i+1])
        );
        q2e_cordic_cell #(.I(i)) u_yaw (
            .clk (clk),
            .en  (en),
            .d   (yaw_pipe[i]),
            .q   (yaw_pipe[i+1])
        );
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_out_reg  <= ROLL_W'(to_q13(roll_pipe[N], FULL_LIMIT));
            pitch_out_reg <= PITCH_W'(to_q13(pitch_pipe[N], HALF_LIMIT));
            yaw_out_reg   <= YAW_W'(to_q13(yaw_pipe[N], FULL_LIMIT));
        end
    end

    assign euler_valid = vld_reg[STAGES-1];
    assign roll_angle  = roll_out_reg;
    assign pitch_angle = pitch_out_reg;
    assign yaw_angle   = yaw_out_reg;

    // checks
    a_ready_rule: assert property (@(posedge clk) disable iff (!rst_n)
        quat_ready == (!euler_valid || euler_ready))
        else $error("input ready does not follow output stall");

    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        euler_valid |-> (roll_angle <= 16'sd25736 && roll_angle >= -16'sd25736))
        else $error("roll outside clamp range");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        euler_valid |-> (pitch_angle <= 15'sd12868 && pitch_angle >= -15'sd12868))
        else $error("pitch outside clamp range");

    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        euler_valid |-> (yaw_angle <= 16'sd25736 && yaw_angle >= -16'sd25736))
        else $error("yaw outside clamp range");

endmodule

[dv/quaternion_to_euler_tb.sv]
// Testbench for quaternion_to_euler: drives quaternions with random gaps and checks
// every Euler angle transfer against a bit-exact fixed-point predictor.
// Depends on q2e_pkg and the quaternion_to_euler RTL.
module quaternion_to_euler_tb;
    import q2e_pkg::*;

    localparam int ITERS       = 16;
    localparam int LATENCY     = 36 + ITERS;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 2000;
    localparam longint ONE30   = 64'sd1073741824;
    localparam longint PI30    = 64'sd3373259426;

    typedef struct packed {
        logic signed [ROLL_W-1:0]  roll;
        logic signed [PITCH_W-1:0] pitch;
        logic signed [YAW_W-1:0]   yaw;
    } angles_t;

    logic clk;
    logic rst_n;
    logic quat_valid;
    logic quat_ready;
    logic signed [IN_W-1:0] quat_w, quat_x, quat_y, quat_z;
    logic euler_valid;
    logic euler_ready;
    logic signed [ROLL_W-1:0]  roll_angle;
    logic signed [PITCH_W-1:0] pitch_angle;
    logic signed [YAW_W-1:0]   yaw_angle;

    angles_t angles_due[$];
    int      mismatches;
    int      idle_cycles;
    bit      sender_gaps;

    quaternion_to_euler #(.CORDIC_ITERATIONS(ITERS)) DUT (.*);

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // atan2 by vectoring CORDIC, Q.30 in and out
    function automatic longint vector_angle(longint yv, longint xv);
        longint acc;
        longint xs;
        longint ys;
        acc = 0;
        if (xv == 0 && yv == 0)
            return 0;
        if (xv < 0)
        begin
            acc = (yv >= 0) ? PI30 : -PI30;
            xv = -xv;
            yv = -yv;
        end
        for (int i = 0; i < ITERS; i++)
        begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (yv >= 0)
            begin
                xv += ys; yv -= xs; acc += longint'(ATAN_TAB[i]);
            end
            else
            begin
                xv -= ys; yv += xs; acc -= longint'(ATAN_TAB[i]);
            end
        end
        return acc;
    endfunction

    function automatic longint to_radians_q13(longint a, longint lim);
        longint r;
        r = (a + (64'sd1 << 16)) >>> 17;
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    // exact floor square root
    function automatic longint floor_root(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic angles_t euler_of(logic signed [IN_W-1:0] qw, qx, qy, qz);
        longint w, x, y, z, t0, t1, t2, t3, t4, rt;
        longint unsigned sq;
        angles_t res;
        w = qw; x = qx; y = qy; z = qz;
        t0 = ONE30 - 2 * (y * y + z * z);
        t1 = 2 * (x * y + w * z);
        t2 = 2 * (w * y - x * z);
        t3 = 2 * (y * z + w * x);
        t4 = ONE30 - 2 * (x * x + y * y);
        if (t2 > ONE30) t2 = ONE30;
        if (t2 < -ONE30) t2 = -ONE30;
        sq = longint'(t2 < 0 ? -t2 : t2);
        sq = sq * sq;
        rt = floor_root((64'd1 << 60) - sq);
        res.roll  = ROLL_W'(to_radians_q13(vector_angle(t3, t4), 25736));
        res.pitch = PITCH_W'(to_radians_q13(vector_angle(t2, rt), 12868));
        res.yaw   = YAW_W'(to_radians_q13(vector_angle(t1, t0), 25736));
        return res;
    endfunction

    // mostly no gap or a short one, a few long
    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    endfunction

    // valid stays high between back-to-back transfers, drops only for a gap
    task automatic send_quat(logic signed [IN_W-1:0] w, x, y, z);
        int gap;
        gap = sender_gaps ? gap_length() : 0;
        if (gap > 0)
        begin
            quat_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        quat_valid <= 1'b1;
        quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
        angles_due.insert(angles_due.size(), euler_of(w, x, y, z));
        @(posedge clk);
        while (!quat_ready) @(posedge clk);
    endtask

    // random quaternion, not normalised: sign and magnitude of each component random
    task automatic send_random_quat();
        logic signed [IN_W-1:0] c[4];
        int kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 4; i++)
        begin
            if (kind < 7)
                c[i] = IN_W'($signed($urandom_range(0, 32767)) >>> $urandom_range(0, 3));
            else
                c[i] = IN_W'($urandom);
            if (kind < 7 && $urandom_range(0, 1))
                c[i] = -c[i];
        end
        send_quat(c[0], c[1], c[2], c[3]);
    endtask

    task automatic test_directed();
        // identity, pure axes, zero, extremes, gimbal lock at both poles, quarter turns, tiny values
        send_quat(16'sd32767, 0, 0, 0);
        send_quat(0, 16'sd32767, 0, 0);
        send_quat(0, 0, 16'sd32767, 0);
        send_quat(0, 0, 0, 16'sd32767);
        send_quat(0, 0, 0, 0);
        send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
        send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
        send_quat(16'sd23170, 0, 16'sd23170, 0);
        send_quat(16'sd23170, 0, -16'sd23170, 0);
        send_quat(16'sd16384, 16'sd16384, 16'sd16384, -16'sd16384);
        send_quat(16'sd16384, -16'sd16384, 16'sd16384, 16'sd16384);
        send_quat(-16'sd32768, 0, 0, 0);
        send_quat(0, -16'sd32768, 16'sd32767, 0);
        send_quat(0, 0, -16'sd32768, 16'sd32767);
        send_quat(16'sd23170, 16'sd23170, 0, 0);
        send_quat(16'sd23170, -16'sd23170, 0, 0);
        send_quat(16'sd23170, 0, 0, -16'sd23170);
        send_quat(16'sd1, -16'sd1, 16'sd1, -16'sd1);
    endtask

    task automatic test_random();
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            sender_gaps = (n % 500) >= 100;
            send_random_quat();
        end
    endtask

    // receiver back-pressure: runs of stall and of full speed
    initial
    begin
        euler_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 3) == 0)
                euler_ready <= 1'b1;
            else
            begin
                euler_ready <= 1'b0;
                repeat (gap_length() + 1) @(posedge clk);
                euler_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && euler_valid && euler_ready)
        begin
            angles_t want;
            if (angles_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer: roll %0d pitch %0d yaw %0d",
                             roll_angle, pitch_angle, yaw_angle);
            end
            else
            begin
                want = angles_due.pop_front();
                if (want.roll !== roll_angle || want.pitch !== pitch_angle
                    || want.yaw !== yaw_angle)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d",
                                 want.roll, roll_angle, want.pitch, pitch_angle,
                                 want.yaw, yaw_angle);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((quat_valid && quat_ready) || (euler_valid && euler_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        quat_valid = 1'b0;
        quat_w = '0; quat_x = '0; quat_y = '0; quat_z = '0;
        mismatches = 0;
        idle_cycles = 0;
        sender_gaps = 1'b1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random();
        quat_valid <= 1'b0;

        // drain, then a quiet spell
        while (angles_due.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0 && angles_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
